[hdl/imt_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and helpers for the IRC message tokenizer.
// Depends on nothing; every module of the tokenizer imports it.
package imt_pkg;

    localparam int MAX_MESSAGE_BYTES_DEF = 8192;
    localparam int MAX_RES = 6;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [3:0] EV_START_MSG    = 4'd0;
    localparam logic [3:0] EV_START_TAGS   = 4'd1;
    localparam logic [3:0] EV_TAG          = 4'd2;
    localparam logic [3:0] EV_PREFIX       = 4'd3;
    localparam logic [3:0] EV_COMMAND      = 4'd4;
    localparam logic [3:0] EV_START_PARAMS = 4'd5;
    localparam logic [3:0] EV_PARAM        = 4'd6;
    localparam logic [3:0] EV_END_PARAMS   = 4'd7;
    localparam logic [3:0] EV_END_MSG      = 4'd8;
    localparam logic [3:0] EV_ERROR        = 4'd9;
    localparam logic [3:0] EV_INCOMPLETE   = 4'd10;

    localparam logic [1:0] ERR_UNEXPECTED_END = 2'd0;
    localparam logic [1:0] ERR_NOT_FOUND      = 2'd1;
    localparam logic [1:0] ERR_SENTINEL       = 2'd2;
    localparam logic [1:0] ERR_TOO_LONG       = 2'd3;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_AT = 8'h40;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // One event, packed so that the kind sits in the lowest bits.
    typedef struct packed {
        logic [13:0] consumed_count;
        logic [1:0]  error_kind;
        logic [13:0] value_length;
        logic [12:0] value_offset;
        logic [13:0] token_length;
        logic [12:0] token_offset;
        logic [3:0]  event_kind;
    } ev_t;

    // All events caused by one input byte.
    typedef struct packed {
        logic [2:0]     n;
        ev_t [MAX_RES-1:0] ev;
    } bundle_t;

    function automatic ev_t mk_ev(logic [3:0] kind, logic [31:0] toff, logic [31:0] tlen,
                                  logic [31:0] voff, logic [31:0] vlen, logic [1:0] err,
                                  logic [31:0] cons);
        ev_t e;
        e.event_kind     = kind;
        e.token_offset   = toff[12:0];
        e.token_length   = tlen[13:0];
        e.value_offset   = voff[12:0];
        e.value_length   = vlen[13:0];
        e.error_kind     = err;
        e.consumed_count = cons[13:0];
        return e;
    endfunction

endpackage

[hdl/imt_front.sv]
`timescale 1ns / 1ps
// Front end of the tokenizer: accepts one byte a cycle while q_full is low,
// keeps the parse state, builds the event bundle for the byte. Uses imt_pkg.
module imt_front import imt_pkg::*; #(
    parameter int MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       in_end,
    input  logic       q_full,
    output logic       in_ready,
    output logic       q_push,
    output bundle_t    q_data
);

    localparam int POS_W = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam logic [31:0] MAXB = 32'(MAX_MESSAGE_BYTES);

    localparam logic [3:0] PH_SEEK_ANY    = 4'd0;
    localparam logic [3:0] PH_TAGS        = 4'd1;
    localparam logic [3:0] PH_SEEK_PC     = 4'd2;
    localparam logic [3:0] PH_PREFIX      = 4'd3;
    localparam logic [3:0] PH_SEEK_CMD    = 4'd4;
    localparam logic [3:0] PH_CMD         = 4'd5;
    localparam logic [3:0] PH_SEEK_PARAMS = 4'd6;
    localparam logic [3:0] PH_PARAMS      = 4'd7;
    localparam logic [3:0] PH_TRAILING    = 4'd8;

    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_CR   = 2'd1;
    localparam logic [1:0] PEND_LF   = 2'd2;

    typedef struct packed {
        logic [3:0]  ph;
        logic        mo;
        logic        po;
        logic [31:0] tb;
        logic [31:0] le;
        logic [31:0] bp;
        logic [1:0]  pt;
        logic        disc;
        logic [2:0]  n;
        ev_t [MAX_RES-1:0] ev;
    } work_t;

    logic [3:0]       phase_reg, phase_next;
    logic             msg_open_reg, msg_open_next;
    logic             params_open_reg, params_open_next;
    logic [POS_W-1:0] token_begin_reg, token_begin_next;
    logic [POS_W-1:0] last_eq_reg, last_eq_next;
    logic [POS_W-1:0] byte_pos_reg, byte_pos_next;
    logic [1:0]       pending_reg, pending_next;
    logic             discard_reg, discard_next;
    work_t            w;

    function automatic work_t f_emit(work_t wi, ev_t e);
        work_t wo;
        wo = wi;
        if (wo.n < 3'(MAX_RES)) begin
            wo.ev[wo.n] = e;
            wo.n = wo.n + 3'd1;
        end
        return wo;
    endfunction

    function automatic work_t f_fail(work_t wi, logic [1:0] k);
        work_t wo;
        wo = f_emit(wi, mk_ev(EV_ERROR, 0, 0, 0, 0, k, 0));
        wo.disc = 1'b1;
        return wo;
    endfunction

    function automatic work_t f_fresh(work_t wi);
        work_t wo;
        wo = wi;
        wo.ph = PH_SEEK_ANY;
        wo.mo = 1'b0;
        wo.po = 1'b0;
        wo.tb = '0;
        wo.le = '0;
        wo.bp = '0;
        wo.pt = PEND_NONE;
        return wo;
    endfunction

    function automatic work_t f_finish(work_t wi, logic [31:0] t, logic [31:0] cons);
        work_t       wo;
        logic [31:0] len;
        wo = wi;
        len = (t >= wo.tb) ? t - wo.tb : 32'd0;
        if (wo.ph >= PH_CMD) begin
            if (wo.ph == PH_CMD) begin
                wo = f_emit(wo, mk_ev(EV_COMMAND, wo.tb, len, 0, 0, ERR_UNEXPECTED_END, 0));
            end else if (wo.ph == PH_PARAMS || wo.ph == PH_TRAILING) begin
                wo = f_emit(wo, mk_ev(EV_PARAM, wo.tb, len, 0, 0, ERR_UNEXPECTED_END, 0));
                wo = f_emit(wo, mk_ev(EV_END_PARAMS, 0, 0, 0, 0, ERR_UNEXPECTED_END, 0));
            end else if (wo.po) begin
                wo = f_emit(wo, mk_ev(EV_END_PARAMS, 0, 0, 0, 0, ERR_UNEXPECTED_END, 0));
            end
            wo = f_emit(wo, mk_ev(EV_END_MSG, 0, 0, 0, 0, ERR_UNEXPECTED_END, cons));
            wo = f_fresh(wo);
        end else begin
            wo = f_fail(wo, (wo.ph == PH_SEEK_ANY) ? ERR_NOT_FOUND : ERR_UNEXPECTED_END);
        end
        return wo;
    endfunction

    function automatic work_t f_tag(work_t wi, logic [31:0] tail);
        work_t       wo;
        logic [31:0] nlen;
        logic [31:0] voff;
        logic [31:0] vlen;
        wo = wi;
        voff = '0;
        vlen = '0;
        if (wo.le != 0 && wo.le >= wo.tb) begin
            nlen = wo.le - wo.tb;
            voff = wo.le + 32'd1;
            vlen = (tail >= voff) ? tail - voff : 32'd0;
            if (vlen == 0) voff = '0;
        end else begin
            nlen = (tail >= wo.tb) ? tail - wo.tb : 32'd0;
        end
        wo = f_emit(wo, mk_ev(EV_TAG, wo.tb, nlen, voff, vlen, ERR_UNEXPECTED_END, 0));
        wo.le = '0;
        return wo;
    endfunction

    function automatic work_t f_open_msg(work_t wi);
        work_t wo;
        wo = wi;
        if (!wo.mo) begin
            wo = f_emit(wo, mk_ev(EV_START_MSG, 0, 0, 0, 0, ERR_UNEXPECTED_END, 0));
            wo.mo = 1'b1;
        end
        return wo;
    endfunction

    function automatic work_t f_take(work_t wi, logic [7:0] b, logic e);
        work_t       wo;
        logic [31:0] p;
        logic [31:0] len;
        logic        ws;
        logic [3:0]  ph0;
        wo = wi;
        p = wo.bp;
        ws = (b == CH_SPACE);
        if (p >= MAXB) begin
            return f_fail(wo, ERR_TOO_LONG);
        end
        wo.bp = p + 32'd1;
        if (ws && wo.ph != PH_TRAILING) begin
            len = p - wo.tb;
            case (wo.ph)
                PH_TAGS: begin
                    if (wo.tb != p) begin
                        wo = f_tag(wo, p);
                        wo.tb = p + 32'd1;
                        wo.ph = PH_SEEK_PC;
                    end
                end
                PH_PREFIX: begin
                    wo = f_emit(wo, mk_ev(EV_PREFIX, wo.tb, len, 0, 0, ERR_UNEXPECTED_END, 0));
                    wo.tb = p + 32'd1;
                    wo.ph = PH_SEEK_CMD;
                end
                PH_CMD: begin
                    wo = f_emit(wo, mk_ev(EV_COMMAND, wo.tb, len, 0, 0, ERR_UNEXPECTED_END, 0));
                    wo.tb = p + 32'd1;
                    wo.ph = PH_SEEK_PARAMS;
                end
                PH_PARAMS: begin
                    wo = f_emit(wo, mk_ev(EV_PARAM, wo.tb, len, 0, 0, ERR_UNEXPECTED_END, 0));
                    wo.tb = p + 32'd1;
                    wo.ph = PH_SEEK_PARAMS;
                end
                default: begin
                    wo.tb = p + 32'd1;
                end
            endcase
        end
        if (b == CH_CR || b == CH_LF) begin
            if (wo.ph == PH_TAGS) wo = f_fail(wo, ERR_UNEXPECTED_END);
            else if (e) wo = f_finish(wo, p, p + 32'd1);
            else wo.pt = (b == CH_CR) ? PEND_CR : PEND_LF;
            return wo;
        end
        ph0 = wo.ph;
        if (b == CH_AT && ph0 == PH_SEEK_ANY) begin
            wo.ph = PH_TAGS;
            wo = f_open_msg(wo);
            wo = f_emit(wo, mk_ev(EV_START_TAGS, 0, 0, 0, 0, ERR_UNEXPECTED_END, 0));
            wo.tb = p + 32'd1;
            wo.le = '0;
        end else if (ph0 == PH_TAGS) begin
            if (b == CH_SEMI) begin
                wo = f_tag(wo, p);
                wo.tb = p + 32'd1;
            end else if (b == CH_EQUALS) begin
                wo.le = p;
            end
        end else if (b == CH_COLON && (ph0 == PH_SEEK_ANY || ph0 == PH_SEEK_PC)) begin
            wo.ph = PH_PREFIX;
            wo = f_open_msg(wo);
            wo.tb = p + 32'd1;
        end else if (!ws && (ph0 == PH_SEEK_ANY || ph0 == PH_SEEK_PC
                             || ph0 == PH_SEEK_CMD)) begin
            wo = f_open_msg(wo);
            wo.ph = PH_CMD;
            wo.tb = p;
        end else if (ph0 == PH_SEEK_PARAMS && !ws) begin
            if (!wo.po) begin
                wo = f_emit(wo, mk_ev(EV_START_PARAMS, 0, 0, 0, 0, ERR_UNEXPECTED_END, 0));
                wo.po = 1'b1;
            end
            if (b == CH_COLON) begin
                wo.tb = p + 32'd1;
                wo.ph = PH_TRAILING;
            end else begin
                wo.tb = p;
                wo.ph = PH_PARAMS;
            end
        end
        return wo;
    endfunction

    always_comb begin
        logic        go;
        logic [7:0]  same;
        logic [7:0]  comp;
        logic [31:0] t;
        w = '0;
        w.ph = phase_reg;
        w.mo = msg_open_reg;
        w.po = params_open_reg;
        w.tb = 32'(token_begin_reg);
        w.le = 32'(last_eq_reg);
        w.bp = 32'(byte_pos_reg);
        w.pt = pending_reg;
        w.disc = discard_reg;
        go = 1'b1;
        same = CH_CR;
        comp = CH_LF;
        t = '0;
        if (!w.disc) begin
            if (w.pt != PEND_NONE) begin
                same = (w.pt == PEND_CR) ? CH_CR : CH_LF;
                comp = (w.pt == PEND_CR) ? CH_LF : CH_CR;
                t = w.bp - 32'd1;
                w.pt = PEND_NONE;
                go = 1'b0;
                if (in_byte == same) begin
                    w = f_fail(w, ERR_SENTINEL);
                end else if (in_byte == comp) begin
                    if (w.bp >= MAXB) w = f_fail(w, ERR_TOO_LONG);
                    else w = f_finish(w, t, w.bp + 32'd1);
                end else begin
                    w = f_finish(w, t, t + 32'd1);
                    go = !w.disc;
                end
            end
            if (go) w = f_take(w, in_byte, in_end);
        end
        if (in_end) begin
            if (!w.disc && w.bp > 0) begin
                if (w.ph < PH_SEEK_CMD) w = f_fail(w, ERR_UNEXPECTED_END);
                else w = f_emit(w, mk_ev(EV_INCOMPLETE, 0, 0, 0, 0, ERR_UNEXPECTED_END, w.bp));
            end
            w = f_fresh(w);
            w.disc = 1'b0;
        end
        phase_next       = w.ph;
        msg_open_next    = w.mo;
        params_open_next = w.po;
        token_begin_next = w.tb[POS_W-1:0];
        last_eq_next     = w.le[POS_W-1:0];
        byte_pos_next    = w.bp[POS_W-1:0];
        pending_next     = w.pt;
        discard_next     = w.disc;
    end

    assign in_ready  = !q_full;
    assign q_push    = in_valid && in_ready && (w.n != 3'd0);
    assign q_data.n  = w.n;
    assign q_data.ev = w.ev;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_SEEK_ANY;
            msg_open_reg    <= 1'b0;
            params_open_reg <= 1'b0;
            token_begin_reg <= '0;
            last_eq_reg     <= '0;
            byte_pos_reg    <= '0;
            pending_reg     <= PEND_NONE;
            discard_reg     <= 1'b0;
        end else if (in_valid && in_ready) begin
            phase_reg       <= phase_next;
            msg_open_reg    <= msg_open_next;
            params_open_reg <= params_open_next;
            token_begin_reg <= token_begin_next;
            last_eq_reg     <= last_eq_next;
            byte_pos_reg    <= byte_pos_next;
            pending_reg     <= pending_next;
            discard_reg     <= discard_next;
        end
    end

endmodule

[hdl/imt_queue.sv]
`timescale 1ns / 1ps
// Short queue of event bundles between the front and back ends.
// Uses imt_pkg for the bundle type and depth.
module imt_queue import imt_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  bundle_t push_data,
    input  logic    pop,
    output logic    full,
    output logic    not_empty,
    output bundle_t head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    bundle_t           mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_reg, rd_reg;
    logic [PTR_W:0]    count_reg;

    assign full      = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) mem[wr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop) rd_reg <= rd_reg + 1'b1;
            if (push && !pop) count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

endmodule

[hdl/imt_back.sv]
`timescale 1ns / 1ps
// Back end of the tokenizer: takes bundles from the queue and sends their
// events one beat at a time, marking the last one. Uses imt_pkg.
module imt_back import imt_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_not_empty,
    input  bundle_t q_head,
    output logic    q_pop,
    output logic    out_valid,
    input  logic    out_ready,
    output ev_t     out_ev,
    output logic    out_last
);

    bundle_t    cur_reg;
    logic       valid_reg;
    logic [2:0] idx_reg;
    logic       done;

    assign out_valid = valid_reg;
    assign out_ev    = cur_reg.ev[idx_reg];
    assign out_last  = (idx_reg == cur_reg.n - 3'd1);
    assign done      = valid_reg && out_ready && out_last;
    assign q_pop     = q_not_empty && (!valid_reg || done);

    always_ff @(posedge aclk) begin
        if (q_pop) cur_reg <= q_head;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 3'd0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
            idx_reg   <= 3'd0;
        end else if (done) begin
            valid_reg <= 1'b0;
            idx_reg   <= 3'd0;
        end else if (valid_reg && out_ready) begin
            idx_reg <= idx_reg + 3'd1;
        end
    end

endmodule

[hdl/irc_message_tokenizer_core.sv]
`timescale 1ns / 1ps
// IRC message tokenizer with IRCv3 tags. One byte is taken every cycle while the
// four-bundle event queue has room; the events of an accepted byte are held in the
// queue, then in the back end's bundle register, before they are presented. A byte
// causes up to six events, one per beat, so sustained throughput is one byte a cycle
// while bytes average one event or fewer and m_tready stays high; the single output
// port sets the limit. Reset (aresetn low, synchronous) returns the parser to the
// start of a message, clears the queue and drops any event in flight.
module irc_message_tokenizer_core import imt_pkg::*; #(
    parameter int MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,   // buffer_end
    output logic        m_tvalid,
    input  logic        m_tready,
    // token_offset, token_length, value_offset, value_length, error_kind,
    // consumed_count, then zero fill
    output logic [71:0] m_tdata,
    output logic [3:0]  m_tuser,   // event_kind
    output logic        m_tlast    // last_of_run
);

    bundle_t q_in;
    bundle_t q_head;
    logic    q_push;
    logic    q_pop;
    logic    q_full;
    logic    q_not_empty;
    ev_t     ev;

    // The front end parses each accepted byte and pushes its events as one bundle.
    imt_front #(
        .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_byte  (s_tdata),
        .in_end   (s_tlast),
        .q_full   (q_full),
        .in_ready (s_tready),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    // The queue lets the parser run on while the consumer stalls.
    imt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // The back end unpacks each bundle into beats.
    imt_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_ev      (ev),
        .out_last    (m_tlast)
    );

    assign m_tdata = {2'd0, ev.consumed_count, ev.error_kind, ev.value_length,
                      ev.value_offset, ev.token_length, ev.token_offset};
    assign m_tuser = ev.event_kind;

endmodule

[bench/irc_message_tokenizer_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the IRC message tokenizer core: directed and random bytes.
// Depends on imt_pkg and irc_message_tokenizer_core; predicts events in-bench.
module irc_message_tokenizer_core_tb;
    import imt_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int MAXB = MAX_MESSAGE_BYTES_DEF;

    // Phases of the tokenizer as the bench tracks them.
    typedef enum int {
        PH_SEEK_ANY, PH_TAGS, PH_SEEK_PC, PH_PREFIX, PH_SEEK_CMD,
        PH_CMD, PH_SEEK_PARAMS, PH_PARAMS, PH_TRAILING
    } phase_e;
    typedef enum int {TERM_NONE, TERM_CR, TERM_LF} term_e;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    irc_message_tokenizer_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Predicted event beats, oldest first, with their last-of-run flag.
    ev_t  event_q[$];
    logic last_q[$];

    int   fail_count = 0;
    int   bytes_sent = 0;
    int   events_seen = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    bit   recv_hold = 1'b0;

    // Tokenizer state mirrored by the predictor.
    phase_e phase;
    bit     msg_open, prm_open, dropping;
    int     tok_begin, eq_pos, pos;
    term_e  pend;
    ev_t    step_ev[$];

    task automatic push_ev(logic [3:0] k, int toff, int tlen, int voff, int vlen,
                           logic [1:0] err, int cons);
        ev_t e;
        e.event_kind = k;
        e.token_offset = toff[12:0];
        e.token_length = tlen[13:0];
        e.value_offset = voff[12:0];
        e.value_length = vlen[13:0];
        e.error_kind = err;
        e.consumed_count = cons[13:0];
        if (step_ev.size() < MAX_RES) step_ev.push_back(e);
    endtask

    task automatic restart_msg();
        phase = PH_SEEK_ANY; msg_open = 0; prm_open = 0;
        tok_begin = 0; eq_pos = 0; pos = 0; pend = TERM_NONE;
    endtask

    task automatic raise_err(logic [1:0] k);
        push_ev(EV_ERROR, 0, 0, 0, 0, k, 0);
        dropping = 1;
    endtask

    task automatic tag_ev(int tail);
        int nlen, voff, vlen;
        voff = 0; vlen = 0;
        if (eq_pos != 0 && eq_pos >= tok_begin) begin
            nlen = eq_pos - tok_begin;
            voff = eq_pos + 1;
            vlen = tail >= voff ? tail - voff : 0;
            if (vlen == 0) voff = 0;
        end else begin
            nlen = tail >= tok_begin ? tail - tok_begin : 0;
        end
        push_ev(EV_TAG, tok_begin, nlen, voff, vlen, ERR_UNEXPECTED_END, 0);
        eq_pos = 0;
    endtask

    task automatic open_msg();
        if (!msg_open) begin
            push_ev(EV_START_MSG, 0, 0, 0, 0, ERR_UNEXPECTED_END, 0);
            msg_open = 1;
        end
    endtask

    // Closes the message at terminator position t, or raises an error before a command.
    task automatic close_msg(int t, int cons);
        int len;
        len = t >= tok_begin ? t - tok_begin : 0;
        if (phase >= PH_CMD) begin
            if (phase == PH_CMD) begin
                push_ev(EV_COMMAND, tok_begin, len, 0, 0, ERR_UNEXPECTED_END, 0);
            end else if (phase == PH_PARAMS || phase == PH_TRAILING) begin
                push_ev(EV_PARAM, tok_begin, len, 0, 0, ERR_UNEXPECTED_END, 0);
                push_ev(EV_END_PARAMS, 0, 0, 0, 0, ERR_UNEXPECTED_END, 0);
            end else if (prm_open) begin
                push_ev(EV_END_PARAMS, 0, 0, 0, 0, ERR_UNEXPECTED_END, 0);
            end
            push_ev(EV_END_MSG, 0, 0, 0, 0, ERR_UNEXPECTED_END, cons);
            restart_msg();
        end else begin
            raise_err(phase == PH_SEEK_ANY ? ERR_NOT_FOUND : ERR_UNEXPECTED_END);
        end
    endtask

    task automatic parse_byte(logic [7:0] b, bit fin);
        int p;
        bit ws;
        phase_e ph;
        p = pos;
        ws = (b == CH_SPACE);
        if (p >= MAXB) begin
            raise_err(ERR_TOO_LONG);
            return;
        end
        pos = p + 1;
        if (ws && phase != PH_TRAILING) begin
            case (phase)
                PH_TAGS: begin
                    if (tok_begin != p) begin
                        tag_ev(p);
                        tok_begin = p + 1;
                        phase = PH_SEEK_PC;
                    end
                end
                PH_PREFIX: begin
                    push_ev(EV_PREFIX, tok_begin, p - tok_begin, 0, 0, ERR_UNEXPECTED_END, 0);
                    tok_begin = p + 1;
                    phase = PH_SEEK_CMD;
                end
                PH_CMD: begin
                    push_ev(EV_COMMAND, tok_begin, p - tok_begin, 0, 0, ERR_UNEXPECTED_END, 0);
                    tok_begin = p + 1;
                    phase = PH_SEEK_PARAMS;
                end
                PH_PARAMS: begin
                    push_ev(EV_PARAM, tok_begin, p - tok_begin, 0, 0, ERR_UNEXPECTED_END, 0);
                    tok_begin = p + 1;
                    phase = PH_SEEK_PARAMS;
                end
                default: tok_begin = p + 1;
            endcase
        end
        if (b == CH_CR || b == CH_LF) begin
            if (phase == PH_TAGS) raise_err(ERR_UNEXPECTED_END);
            else if (fin) close_msg(p, p + 1);
            else pend = (b == CH_CR) ? TERM_CR : TERM_LF;
            return;
        end
        ph = phase;
        if (b == CH_AT && ph == PH_SEEK_ANY) begin
            phase = PH_TAGS;
            open_msg();
            push_ev(EV_START_TAGS, 0, 0, 0, 0, ERR_UNEXPECTED_END, 0);
            tok_begin = p + 1;
            eq_pos = 0;
        end else if (ph == PH_TAGS) begin
            if (b == CH_SEMI) begin
                tag_ev(p);
                tok_begin = p + 1;
            end else if (b == CH_EQUALS) begin
                eq_pos = p;
            end
        end else if (b == CH_COLON && (ph == PH_SEEK_ANY || ph == PH_SEEK_PC)) begin
            phase = PH_PREFIX;
            open_msg();
            tok_begin = p + 1;
        end else if (!ws && (ph == PH_SEEK_ANY || ph == PH_SEEK_PC || ph == PH_SEEK_CMD)) begin
            open_msg();
            phase = PH_CMD;
            tok_begin = p;
        end else if (ph == PH_SEEK_PARAMS && !ws) begin
            if (!prm_open) begin
                push_ev(EV_START_PARAMS, 0, 0, 0, 0, ERR_UNEXPECTED_END, 0);
                prm_open = 1;
            end
            if (b == CH_COLON) begin
                tok_begin = p + 1;
                phase = PH_TRAILING;
            end else begin
                tok_begin = p;
                phase = PH_PARAMS;
            end
        end
    endtask

    // Works out every event that one accepted byte causes and queues them.
    task automatic predict_events(logic [7:0] b, bit fin);
        bit go;
        logic [7:0] same, comp;
        int t;
        step_ev.delete();
        if (!dropping) begin
            go = 1;
            if (pend != TERM_NONE) begin
                same = (pend == TERM_CR) ? CH_CR : CH_LF;
                comp = (pend == TERM_CR) ? CH_LF : CH_CR;
                t = pos - 1;
                pend = TERM_NONE;
                go = 0;
                if (b == same) begin
                    raise_err(ERR_SENTINEL);
                end else if (b == comp) begin
                    if (pos >= MAXB) raise_err(ERR_TOO_LONG);
                    else close_msg(t, pos + 1);
                end else begin
                    close_msg(t, t + 1);
                    go = !dropping;
                end
            end
            if (go) parse_byte(b, fin);
        end
        if (fin) begin
            if (!dropping && pos > 0) begin
                if (phase < PH_SEEK_CMD) raise_err(ERR_UNEXPECTED_END);
                else push_ev(EV_INCOMPLETE, 0, 0, 0, 0, ERR_UNEXPECTED_END, pos);
            end
            restart_msg();
            dropping = 0;
        end
        foreach (step_ev[i]) begin
            event_q.push_back(step_ev[i]);
            last_q.push_back(i == step_ev.size() - 1);
        end
    endtask

    // Offers one byte, waits for its beat to be accepted, then predicts it.
    // The valid line stays high into the next byte unless the sender idles.
    task automatic send_byte(logic [7:0] b, bit fin);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_events(b, fin);
        bytes_sent++;
    endtask

    task automatic send_text(string s, bit fin_at_end);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], fin_at_end && i == s.len() - 1);
    endtask

    task automatic drain_events();
        s_tvalid <= 1'b0;
        while (event_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(posedge aclk) begin
        if (!aresetn || recv_hold) m_tready <= 1'b0;
        else m_tready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end

    // Compares each accepted event beat with the oldest prediction.
    always @(posedge aclk) begin
        ev_t got, want;
        logic want_last;
        if (aresetn && m_tvalid && m_tready) begin
            got.event_kind     = m_tuser;
            got.token_offset   = m_tdata[12:0];
            got.token_length   = m_tdata[26:13];
            got.value_offset   = m_tdata[39:27];
            got.value_length   = m_tdata[53:40];
            got.error_kind     = m_tdata[55:54];
            got.consumed_count = m_tdata[69:56];
            events_seen++;
            if (event_q.size() == 0) begin
                $error("unexpected event beat kind=%0d", got.event_kind);
                fail_count++;
            end else begin
                want = event_q.pop_front();
                want_last = last_q.pop_front();
                if (got.event_kind != want.event_kind) begin
                    $error("event_kind exp %0d got %0d", want.event_kind, got.event_kind);
                    fail_count++;
                end
                if (got.token_offset != want.token_offset) begin
                    $error("token_offset exp %0d got %0d", want.token_offset, got.token_offset);
                    fail_count++;
                end
                if (got.token_length != want.token_length) begin
                    $error("token_length exp %0d got %0d", want.token_length, got.token_length);
                    fail_count++;
                end
                if (got.value_offset != want.value_offset) begin
                    $error("value_offset exp %0d got %0d", want.value_offset, got.value_offset);
                    fail_count++;
                end
                if (got.value_length != want.value_length) begin
                    $error("value_length exp %0d got %0d", want.value_length, got.value_length);
                    fail_count++;
                end
                if (got.error_kind != want.error_kind) begin
                    $error("error_kind exp %0d got %0d", want.error_kind, got.error_kind);
                    fail_count++;
                end
                if (got.consumed_count != want.consumed_count) begin
                    $error("consumed_count exp %0d got %0d",
                           want.consumed_count, got.consumed_count);
                    fail_count++;
                end
                if (m_tlast != want_last) begin
                    $error("last_of_run exp %0d got %0d", want_last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: cycles without any accepted beat on either side.
    always @(posedge aclk) begin
        int quiet;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
        else quiet++;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic test_directed();
        send_text("@a=b;c;d= :nick!u@h PRIVMSG #chan :hi there\r\n", 0);
        send_text("PING x\n\r", 0);
        send_text("CMD a b \n", 0);
        send_text("CMD\r\r", 0);
        send_text("x", 1);
        send_text("  \n", 0);
        send_text("z", 1);
        send_text("@t\n", 0);
        send_text("y", 1);
        send_text("CMD p\r", 1);
        send_text(":pre", 1);
        send_text("NICK a", 1);
        send_byte(8'hFF, 0);
        send_byte(8'h00, 1);
        send_text("A\rB\n", 1);
        drain_events();
    endtask

    function automatic logic [7:0] rand_char();
        int r;
        r = $urandom_range(99);
        if (r < 8) return CH_SPACE;
        if (r < 12) return CH_SEMI;
        if (r < 16) return CH_EQUALS;
        if (r < 19) return CH_COLON;
        if (r < 21) return CH_AT;
        if (r < 23) return 8'($urandom_range(255));
        return 8'(8'h61 + $urandom_range(25));
    endfunction

    // Mostly well-formed messages with random content, some noise.
    task automatic test_random(int n_bytes);
        int start;
        int k;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            if ($urandom_range(9) < 8) begin
                if ($urandom_range(2) == 0) begin
                    send_byte(CH_AT, 0);
                    k = $urandom_range(4);
                    repeat (k) send_byte(rand_char() == CH_SPACE ? CH_SEMI : rand_char(), 0);
                    send_byte(CH_SPACE, 0);
                end
                if ($urandom_range(2) == 0) begin
                    send_byte(CH_COLON, 0);
                    repeat ($urandom_range(1, 3)) send_byte(8'(8'h61 + $urandom_range(25)), 0);
                    send_byte(CH_SPACE, 0);
                end
                k = $urandom_range(1, 8);
                repeat (k) send_byte(rand_char(), 0);
                case ($urandom_range(5))
                    0: send_byte(CH_CR, 0);
                    1: send_byte(CH_LF, 0);
                    2: begin send_byte(CH_CR, 0); send_byte(CH_LF, 0); end
                    3: begin send_byte(CH_LF, 0); send_byte(CH_CR, 0); end
                    4: send_byte(CH_CR, 1);
                    default: send_byte(rand_char(), 1);
                endcase
            end else begin
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
            end
        end
        send_byte(CH_LF, 1);
        drain_events();
    endtask

    // The receiver holds off while the sender keeps offering, filling the queue.
    task automatic test_backpressure();
        fork
            begin
                recv_hold = 1'b1;
                repeat (200) @(posedge aclk);
                recv_hold = 1'b0;
            end
            send_text("@a=1;b=2;c :p CMD x y :z w\r\n", 0);
        join
        drain_events();
    endtask

    initial begin
        restart_msg();
        dropping = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        send_idle_pct = 9;  recv_idle_pct = 73;
        test_random(35);
        test_backpressure();
        send_idle_pct = 73; recv_idle_pct = 9;
        test_random(35);
        send_idle_pct = 0;  recv_idle_pct = 0;
        test_random(35);
        drain_events();
        $display("Run covered tags, prefixes, commands, params, every terminator form,");
        $display("errors and incomplete buffers: %0d bytes, %0d events.", bytes_sent, events_seen);
        if (fail_count == 0 && event_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
